// File: src/dvscan_pkg.sv
// Shared constants, register map and result type for the dword value scanner.
package dvscan_pkg;

  localparam int CONTEXT_BYTES_DEF = 8;
  localparam int NUM_VALUES_DEF    = 4;
  localparam int NUM_WANTED        = 4;

  localparam int DATA_W = 32;
  localparam int CTX_W  = 64;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_CMP_COUNT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_REPORT_LIMIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_WANTED_0     = 3'd2;
  localparam logic [IDX_W-1:0] REG_WANTED_1     = 3'd3;
  localparam logic [IDX_W-1:0] REG_WANTED_2     = 3'd4;
  localparam logic [IDX_W-1:0] REG_WANTED_3     = 3'd5;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] offset;
    logic [DATA_W-1:0] value;
    logic [CTX_W-1:0]  lead_bytes;
    logic [CNT_W-1:0]  lead_count;
    logic [CTX_W-1:0]  trail_bytes;
    logic [CNT_W-1:0]  trail_count;
    logic [DATA_W-1:0] total;
    logic              capped;
    logic              last;
  } result_t;

endpackage

// File: src/dword_value_scan_with_context_core.sv
// Byte-stream scanner for 32-bit little-endian values with leading and trailing context.
//
// Input channel: one buffer byte per transaction (data_byte_i, buffer_end_i on the last
// byte), taken when in_valid_i is high and in_stall_o is low. Output channel: one result
// per transaction on the result ports, taken when out_valid_o is high and out_stall_i low.
// Configuration: APB-style registers at 4*index (compare count, report limit, wanted values).
// Throughput: one byte per cycle while input is not stalled. A match report is pushed
// into the output queue in the cycle that the byte completing its trailing context is
// taken. After the last byte of a buffer the flush sequencer emits the pending reports,
// one per cycle while the skid entry is free, then the summary; input stalls while it runs.
// A two-entry output queue (result register plus skid) lets a byte be taken while a
// finished result waits; input stalls when the skid entry is occupied or a flush runs.
// Reset: configuration returns to defaults (no values compared, no report limit) and the
// per-buffer counters, marks and fill level clear. When the receiver stalls, the result
// holds and input stops once a further result has to wait in the skid entry.
module dword_value_scan_with_context_core #(
  parameter int CONTEXT_BYTES = dvscan_pkg::CONTEXT_BYTES_DEF,
  parameter int NUM_VALUES    = dvscan_pkg::NUM_VALUES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           buffer_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           result_kind_o,
  output logic [dvscan_pkg::DATA_W-1:0]  match_offset_o,
  output logic [dvscan_pkg::DATA_W-1:0]  match_value_o,
  output logic [dvscan_pkg::CTX_W-1:0]   leading_bytes_o,
  output logic [dvscan_pkg::CNT_W-1:0]   leading_count_o,
  output logic [dvscan_pkg::CTX_W-1:0]   trailing_bytes_o,
  output logic [dvscan_pkg::CNT_W-1:0]   trailing_count_o,
  output logic [dvscan_pkg::DATA_W-1:0]  total_count_o,
  output logic                           capped_o,
  output logic                           last_result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dvscan_pkg::ADDR_W-1:0]  paddr,
  input  logic [dvscan_pkg::DATA_W-1:0]  pwdata,
  output logic [dvscan_pkg::DATA_W-1:0]  prdata,
  output logic                           pready
);

  localparam int HIST_DEPTH = 2 * CONTEXT_BYTES + 4;
  localparam int MARK_DEPTH = CONTEXT_BYTES + 1;
  localparam int HIW        = $clog2(HIST_DEPTH);
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int NCMP       = (NUM_VALUES < dvscan_pkg::NUM_WANTED) ?
                              NUM_VALUES : dvscan_pkg::NUM_WANTED;
  localparam int DW         = dvscan_pkg::DATA_W;
  localparam int CW         = dvscan_pkg::CNT_W;

  typedef logic [7:0] hist_t [HIST_DEPTH];

  function automatic dvscan_pkg::result_t make_report(input hist_t h,
                                                      input logic [CW-1:0] k,
                                                      input logic [FILL_W-1:0] fill,
                                                      input logic [DW-1:0] pos);
    dvscan_pkg::result_t r;
    logic [5:0] k6;
    logic [5:0] f6;
    logic [5:0] avail;
    logic [5:0] lead6;
    r     = '0;
    k6    = 6'(k);
    f6    = 6'(fill);
    avail = (f6 >= k6 + 6'd4) ? (f6 - k6 - 6'd4) : 6'd0;
    lead6 = (avail > 6'(CONTEXT_BYTES)) ? 6'(CONTEXT_BYTES) : avail;
    r.kind   = dvscan_pkg::KIND_REPORT;
    r.offset = pos - DW'(3) - DW'(k);
    r.value  = {h[HIW'(k6)], h[HIW'(k6 + 6'd1)], h[HIW'(k6 + 6'd2)], h[HIW'(k6 + 6'd3)]};
    for (int j = 0; j < CONTEXT_BYTES; j++) begin
      if (6'(j) < lead6) begin
        r.lead_bytes[8*j +: 8] = h[HIW'(k6 + 6'd3 + lead6 - 6'(j))];
      end
      if (6'(j) < k6) begin
        r.trail_bytes[8*j +: 8] = h[HIW'(k6 - 6'd1 - 6'(j))];
      end
    end
    r.lead_count  = CW'(lead6);
    r.trail_count = k;
    return r;
  endfunction

  // configuration registers
  logic [2:0]    cmp_count_q;
  logic [DW-1:0] report_limit_q;
  logic [DW-1:0] wanted_q [dvscan_pkg::NUM_WANTED];

  // per-buffer state
  hist_t                 hist_q;
  logic [MARK_DEPTH-1:0] marks_q;
  logic [DW-1:0]         pos_q;
  logic [DW-1:0]         reports_q;
  logic [DW-1:0]         total_q;
  logic                  cap_q;
  logic [FILL_W-1:0]     fill_q;

  // flush sequencer
  logic                  flush_active_q;
  logic [MARK_DEPTH-1:0] flush_marks_q;
  logic [FILL_W-1:0]     flush_fill_q;
  logic [DW-1:0]         flush_pos_q;
  logic [DW-1:0]         flush_total_q;
  logic                  flush_cap_q;

  // output queue
  logic                out_valid_q;
  logic                skid_valid_q;
  dvscan_pkg::result_t out_q;
  dvscan_pkg::result_t skid_q;

  logic [dvscan_pkg::IDX_W-1:0] reg_idx;
  logic                         cfg_wr;

  logic                  accept;
  hist_t                 hist_new;
  logic [FILL_W-1:0]     fill_new;
  logic [DW-1:0]         cand;
  logic                  hit;
  logic                  mark0;
  logic [MARK_DEPTH-1:0] marks_new;
  logic [MARK_DEPTH-1:0] marks_keep;
  logic [DW-1:0]         total_new;
  logic [DW-1:0]         reports_new;
  logic                  cap_new;

  logic                  flush_any;
  logic [CW-1:0]         flush_k;
  logic                  push_ok;
  logic                  push;
  dvscan_pkg::result_t   push_data;
  logic                  out_pop;

  assign reg_idx = paddr[dvscan_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      dvscan_pkg::REG_CMP_COUNT:    prdata = DW'(cmp_count_q);
      dvscan_pkg::REG_REPORT_LIMIT: prdata = report_limit_q;
      dvscan_pkg::REG_WANTED_0:     prdata = wanted_q[0];
      dvscan_pkg::REG_WANTED_1:     prdata = wanted_q[1];
      dvscan_pkg::REG_WANTED_2:     prdata = wanted_q[2];
      dvscan_pkg::REG_WANTED_3:     prdata = wanted_q[3];
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_count_q    <= '0;
      report_limit_q <= '1;
      for (int i = 0; i < dvscan_pkg::NUM_WANTED; i++) begin
        wanted_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        dvscan_pkg::REG_CMP_COUNT:    cmp_count_q    <= pwdata[2:0];
        dvscan_pkg::REG_REPORT_LIMIT: report_limit_q <= pwdata;
        dvscan_pkg::REG_WANTED_0:     wanted_q[0]    <= pwdata;
        dvscan_pkg::REG_WANTED_1:     wanted_q[1]    <= pwdata;
        dvscan_pkg::REG_WANTED_2:     wanted_q[2]    <= pwdata;
        dvscan_pkg::REG_WANTED_3:     wanted_q[3]    <= pwdata;
        default: ;
      endcase
    end
  end

  assign push_ok    = !skid_valid_q;
  assign in_stall_o = flush_active_q || skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_q && !out_stall_i;

  always_comb begin
    hist_new[0] = data_byte_i;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      hist_new[i] = hist_q[i-1];
    end
    fill_new = (fill_q < FILL_W'(HIST_DEPTH)) ? fill_q + FILL_W'(1) : fill_q;
    cand     = {hist_new[0], hist_new[1], hist_new[2], hist_new[3]};
    hit      = 1'b0;
    for (int v = 0; v < NCMP; v++) begin
      if ((3'(v) < cmp_count_q) && (wanted_q[v] == cand)) begin
        hit = 1'b1;
      end
    end
    hit = hit && (fill_new >= FILL_W'(4));

    total_new   = total_q;
    reports_new = reports_q;
    cap_new     = cap_q;
    mark0       = 1'b0;
    if (hit) begin
      if (total_q != '1) begin
        total_new = total_q + DW'(1);
      end
      if (reports_q < report_limit_q) begin
        reports_new = reports_q + DW'(1);
        mark0       = 1'b1;
      end else begin
        cap_new = 1'b1;
      end
    end

    marks_new[0] = mark0;
    for (int i = 1; i < MARK_DEPTH; i++) begin
      marks_new[i] = marks_q[i-1];
    end
    marks_keep = marks_new;
    marks_keep[CONTEXT_BYTES] = 1'b0;
  end

  always_comb begin
    flush_any = 1'b0;
    flush_k   = '0;
    for (int i = 0; i < MARK_DEPTH; i++) begin
      if (flush_marks_q[i]) begin
        flush_any = 1'b1;
        flush_k   = CW'(i);
      end
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (flush_active_q) begin
      push = push_ok;
      if (flush_any) begin
        push_data = make_report(hist_q, flush_k, flush_fill_q, flush_pos_q);
      end else begin
        push_data.kind   = dvscan_pkg::KIND_SUMMARY;
        push_data.total  = flush_total_q;
        push_data.capped = flush_cap_q;
        push_data.last   = 1'b1;
      end
    end else if (accept && !buffer_end_i && marks_new[CONTEXT_BYTES]) begin
      push           = 1'b1;
      push_data      = make_report(hist_new, CW'(CONTEXT_BYTES), fill_new, pos_q);
      push_data.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q <= hist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q   <= '0;
      pos_q     <= '0;
      reports_q <= '0;
      total_q   <= '0;
      cap_q     <= 1'b0;
      fill_q    <= '0;
    end else if (accept) begin
      if (buffer_end_i) begin
        marks_q   <= '0;
        pos_q     <= '0;
        reports_q <= '0;
        total_q   <= '0;
        cap_q     <= 1'b0;
        fill_q    <= '0;
      end else begin
        marks_q   <= marks_keep;
        pos_q     <= pos_q + DW'(1);
        reports_q <= reports_new;
        total_q   <= total_new;
        cap_q     <= cap_new;
        fill_q    <= fill_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_active_q <= 1'b0;
      flush_marks_q  <= '0;
    end else if (accept && buffer_end_i) begin
      flush_active_q <= 1'b1;
      flush_marks_q  <= marks_new;
    end else if (flush_active_q && push_ok) begin
      if (flush_any) begin
        flush_marks_q <= flush_marks_q & ~(MARK_DEPTH'(1) << flush_k);
      end else begin
        flush_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && buffer_end_i) begin
      flush_fill_q  <= fill_new;
      flush_pos_q   <= pos_q;
      flush_total_q <= total_new;
      flush_cap_q   <= cap_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_pop || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : push_data;
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign match_offset_o   = out_q.offset;
  assign match_value_o    = out_q.value;
  assign leading_bytes_o  = out_q.lead_bytes;
  assign leading_count_o  = out_q.lead_count;
  assign trailing_bytes_o = out_q.trail_bytes;
  assign trailing_count_o = out_q.trail_count;
  assign total_count_o    = out_q.total;
  assign capped_o         = out_q.capped;
  assign last_result_o    = out_q.last;

endmodule

// File: test/tb_dword_value_scan_with_context_core.sv
`timescale 1ns / 100ps
// Self-checking bench for the dword value scanner: random buffers and settings, checked results.
module tb_dword_value_scan_with_context_core;

  localparam int CTX         = dvscan_pkg::CONTEXT_BYTES_DEF;
  localparam int NVAL        = dvscan_pkg::NUM_VALUES_DEF;
  localparam int NWANT       = dvscan_pkg::NUM_WANTED;
  localparam int DW          = dvscan_pkg::DATA_W;
  localparam int XW          = dvscan_pkg::CTX_W;
  localparam int CW          = dvscan_pkg::CNT_W;
  localparam int AW          = dvscan_pkg::ADDR_W;
  localparam int IW          = dvscan_pkg::IDX_W;
  localparam int HIST_DEPTH  = 2 * CTX + 4;
  localparam int MARK_DEPTH  = CTX + 1;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_item_t;

  logic          clk_i        = 1'b0;
  logic          rst_ni       = 1'b0;
  logic          in_valid_i   = 1'b0;
  logic          in_stall_o;
  logic [7:0]    data_byte_i  = '0;
  logic          buffer_end_i = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i  = 1'b0;
  logic          result_kind_o;
  logic [DW-1:0] match_offset_o;
  logic [DW-1:0] match_value_o;
  logic [XW-1:0] leading_bytes_o;
  logic [CW-1:0] leading_count_o;
  logic [XW-1:0] trailing_bytes_o;
  logic [CW-1:0] trailing_count_o;
  logic [DW-1:0] total_count_o;
  logic          capped_o;
  logic          last_result_o;
  logic          psel    = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite  = 1'b0;
  logic [AW-1:0] paddr   = '0;
  logic [DW-1:0] pwdata  = '0;
  logic [DW-1:0] prdata;
  logic          pready;

  // scanner state mirrored for prediction
  logic [2:0]            cfg_count = '0;
  logic [31:0]           cfg_limit = '1;
  logic [31:0]           cfg_wanted [NWANT] = '{default: '0};
  logic [7:0]            s_hist [HIST_DEPTH] = '{default: '0};
  logic [MARK_DEPTH-1:0] s_marks   = '0;
  logic [31:0]           s_pos     = '0;
  logic [31:0]           s_reports = '0;
  logic [31:0]           s_total   = '0;
  logic                  s_cap     = 1'b0;
  int                    s_fill    = 0;

  byte_item_t          byte_feed[$];
  dvscan_pkg::result_t due_results[$];

  int burst_left  = 0;
  int gap_left    = 0;
  int idle_cycles = 0;
  int failures    = 0;
  int shown       = 0;
  int n_queued    = 0;
  int n_bytes     = 0;
  int n_buffers   = 0;
  int n_reports   = 0;
  int n_summaries = 0;
  int n_settings  = 1;

  logic [3:0]  stall_step = '0;
  logic [15:0] stall_bits = '0;

  dword_value_scan_with_context_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .buffer_end_i     (buffer_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .match_offset_o   (match_offset_o),
    .match_value_o    (match_value_o),
    .leading_bytes_o  (leading_bytes_o),
    .leading_count_o  (leading_count_o),
    .trailing_bytes_o (trailing_bytes_o),
    .trailing_count_o (trailing_count_o),
    .total_count_o    (total_count_o),
    .capped_o         (capped_o),
    .last_result_o    (last_result_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic dvscan_pkg::result_t make_report(int k, logic [31:0] pos);
    dvscan_pkg::result_t r;
    int                  avail;
    int                  lead;
    int                  j;
    r = '0;
    avail = (s_fill >= k + 4) ? s_fill - 4 - k : 0;
    lead = (avail < CTX) ? avail : CTX;
    r.kind = dvscan_pkg::KIND_REPORT;
    r.offset = pos - 32'd3 - k;
    r.value = {s_hist[k], s_hist[k+1], s_hist[k+2], s_hist[k+3]};
    for (j = 0; j < lead; j++) r.lead_bytes[8*j +: 8] = s_hist[k + 3 + lead - j];
    r.lead_count = CW'(lead);
    for (j = 0; j < k; j++) r.trail_bytes[8*j +: 8] = s_hist[k - 1 - j];
    r.trail_count = CW'(k);
    return r;
  endfunction

  task automatic step_scanner(input logic [7:0] b, input logic fin);
    dvscan_pkg::result_t r;
    logic [31:0]         pos;
    logic [31:0]         cand;
    logic                hit;
    int                  lim;
    int                  i;
    int                  start_size;
    start_size = due_results.size();
    pos = s_pos;
    for (i = HIST_DEPTH - 1; i > 0; i--) s_hist[i] = s_hist[i-1];
    s_hist[0] = b;
    if (s_fill < HIST_DEPTH) s_fill++;
    s_marks = {s_marks[MARK_DEPTH-2:0], 1'b0};
    if (s_fill >= 4) begin
      cand = {s_hist[0], s_hist[1], s_hist[2], s_hist[3]};
      lim = (int'(cfg_count) < NVAL) ? int'(cfg_count) : NVAL;
      hit = 1'b0;
      for (i = 0; i < lim && i < NWANT; i++) begin
        if (cfg_wanted[i] == cand) hit = 1'b1;
      end
      if (hit) begin
        if (s_total != '1) s_total++;
        if (s_reports < cfg_limit) begin
          s_reports++;
          s_marks[0] = 1'b1;
        end else begin
          s_cap = 1'b1;
        end
      end
    end
    if (s_marks[CTX]) begin
      due_results = {due_results, make_report(CTX, pos)};
      s_marks[CTX] = 1'b0;
    end
    if (fin) begin
      for (i = CTX - 1; i >= 0; i--) begin
        if (s_marks[i]) due_results = {due_results, make_report(i, pos)};
      end
      r = '0;
      r.kind = dvscan_pkg::KIND_SUMMARY;
      r.total = s_total;
      r.capped = s_cap;
      due_results = {due_results, r};
      s_marks = '0;
      s_pos = '0;
      s_reports = '0;
      s_total = '0;
      s_cap = 1'b0;
      s_fill = 0;
    end else begin
      s_pos = pos + 32'd1;
    end
    if (due_results.size() > start_size) begin
      r = due_results[due_results.size() - 1];
      r.last = 1'b1;
      due_results[due_results.size() - 1] = r;
    end
  endtask

  function automatic string describe(dvscan_pkg::result_t r);
    return $sformatf({"kind=%0d off=%h val=%h lead=%h/%0d trail=%h/%0d",
                      " total=%0d capped=%0d last=%0d"},
                     r.kind, r.offset, r.value, r.lead_bytes, r.lead_count, r.trail_bytes,
                     r.trail_count, r.total, r.capped, r.last);
  endfunction

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk_i) begin
    byte_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        step_scanner(data_byte_i, buffer_end_i);
        n_bytes++;
        if (buffer_end_i) n_buffers++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_feed.size() > 0) begin
          nxt = byte_feed.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= nxt.data;
          buffer_end_i <= nxt.fin;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, reloaded each time the 4-bit step counter wraps; bit 15 stays clear
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= stall_bits[stall_step];
      stall_step <= stall_step + 4'd1;
      if (stall_step == 4'd15) begin
        case ($urandom_range(0, 3))
          0: stall_bits <= '0;
          1: stall_bits <= {1'b0, 15'($urandom & $urandom & $urandom)};
          default: stall_bits <= {1'b0, 15'($urandom)};
        endcase
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    dvscan_pkg::result_t seen;
    dvscan_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{kind: result_kind_o, offset: match_offset_o, value: match_value_o,
               lead_bytes: leading_bytes_o, lead_count: leading_count_o,
               trail_bytes: trailing_bytes_o, trail_count: trailing_count_o,
               total: total_count_o, capped: capped_o, last: last_result_o};
      if (due_results.size() == 0) begin
        failures++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: %s", describe(seen));
        end
      end else begin
        want = due_results.pop_front();
        if (want.kind == dvscan_pkg::KIND_SUMMARY) n_summaries++;
        else n_reports++;
        if (seen !== want) begin
          failures++;
          if (shown < 10) begin
            shown++;
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(seen));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      dvscan_pkg::REG_CMP_COUNT:    cfg_count = val[2:0];
      dvscan_pkg::REG_REPORT_LIMIT: cfg_limit = val;
      dvscan_pkg::REG_WANTED_0:     cfg_wanted[0] = val;
      dvscan_pkg::REG_WANTED_1:     cfg_wanted[1] = val;
      dvscan_pkg::REG_WANTED_2:     cfg_wanted[2] = val;
      dvscan_pkg::REG_WANTED_3:     cfg_wanted[3] = val;
      default: ;
    endcase
  endtask

  task automatic feed(input logic [7:0] b, input logic fin);
    byte_item_t it;
    it.data = b;
    it.fin = fin;
    byte_feed = {byte_feed, it};
    n_queued++;
  endtask

  task automatic add_random_buffer(input int len, input logic shaped);
    logic [7:0]  seq[$];
    logic [31:0] w;
    int          run;
    int          i;
    while (seq.size() < len) begin
      if (!shaped) begin
        seq = {seq, 8'($urandom)};
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            w = cfg_wanted[$urandom_range(0, NWANT - 1)];
            for (i = 0; i < 4; i++) seq = {seq, w[8*i +: 8]};
          end
          3: begin
            w = cfg_wanted[$urandom_range(0, NWANT - 1)];
            run = $urandom_range(4, 11);
            for (i = 0; i < run; i++) seq = {seq, w[7:0]};
          end
          default: seq = {seq, 8'($urandom)};
        endcase
      end
    end
    for (i = 0; i < len; i++) feed(seq[i], i == len - 1);
  endtask

  // hold until every byte is taken and every predicted result has arrived
  task automatic wait_idle();
    while (byte_feed.size() != 0 || in_valid_i || due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_wanted();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {4{8'($urandom)}};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          ph;
    int          target;
    int          len;
    int          k;
    logic [31:0] lim;
    logic [2:0]  vc;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: nothing compared, zero bytes must not match
    feed(8'h00, 1'b1);
    repeat (3) feed(8'h00, 1'b0);
    feed(8'h00, 1'b1);
    wait_idle();

    write_reg(dvscan_pkg::REG_CMP_COUNT, 32'd4);
    write_reg(dvscan_pkg::REG_REPORT_LIMIT, 32'hFFFF_FFFF);
    write_reg(dvscan_pkg::REG_WANTED_0, 32'h4433_2211);
    write_reg(dvscan_pkg::REG_WANTED_1, 32'hFFFF_FFFF);
    write_reg(dvscan_pkg::REG_WANTED_2, 32'h0000_0000);
    write_reg(dvscan_pkg::REG_WANTED_3, 32'h807F_01FE);
    n_settings++;
    // match at offset zero flushed with no context
    feed(8'h11, 1'b0);
    feed(8'h22, 1'b0);
    feed(8'h33, 1'b0);
    feed(8'h44, 1'b1);
    // overlapping matches: nine reports from the flush, one with full trailing context
    repeat (11) feed(8'hFF, 1'b0);
    feed(8'hFF, 1'b1);
    // short buffer, summary only
    feed(8'h11, 1'b0);
    feed(8'h22, 1'b0);
    feed(8'h33, 1'b1);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: vc = 3'd4;
        1: vc = 3'd0;
        2: vc = 3'd7;
        3: vc = 3'd1;
        4: vc = 3'd5;
        default: vc = 3'($urandom_range(1, 7));
      endcase
      case (ph)
        0: lim = 32'hFFFF_FFFF;
        2: lim = 32'd0;
        3: lim = 32'd1;
        4: lim = 32'd2;
        default: lim = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 5);
      endcase
      write_reg(dvscan_pkg::REG_CMP_COUNT, {29'd0, vc});
      write_reg(dvscan_pkg::REG_REPORT_LIMIT, lim);
      for (k = 0; k < NWANT; k++) begin
        write_reg(dvscan_pkg::REG_WANTED_0 + IW'(k), pick_wanted());
      end
      n_settings++;
      target = n_queued + PHASE_BYTES;
      while (n_queued < target) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        add_random_buffer(len, $urandom_range(0, 4) != 0);
      end
      wait_idle();
    end

    failures += due_results.size();
    $display("covered %0d bytes in %0d buffers under %0d register settings",
             n_bytes, n_buffers, n_settings);
    $display("checked %0d match reports and %0d summaries, %0d failing",
             n_reports, n_summaries, failures);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
